// ===== src/smdr_pkg.sv =====
// Package for the rounded signed multiply-divide core.
// Holds the channel item types and the control bundle passed along the pipeline.
// No dependencies.
package smdr_pkg;

  localparam int DATA_BITS = 32;

  typedef struct packed {
    logic signed [DATA_BITS-1:0] multiplicand;
    logic signed [DATA_BITS-1:0] multiplier;
    logic signed [DATA_BITS-1:0] divisor;
  } smdr_op_t;

  typedef struct packed {
    logic signed [DATA_BITS-1:0] quotient;
    logic                        saturated;
  } smdr_res_t;

  // Per-item control that rides along with the data through every stage.
  typedef struct packed {
    logic valid;
    logic bypass;  // a is zero or b equals c: the result is a
    logic neg;     // result sign
    logic ovf;     // quotient magnitude above the positive limit, or zero divisor
  } smdr_ctrl_t;

endpackage

// ===== src/smdr_front.sv =====
// Front end of the multiply-divide pipeline: operand decode, product and rounding add.
// Depends on smdr_pkg.
module smdr_front #(
  parameter int OPERAND_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  smdr_pkg::smdr_op_t      op,
  output smdr_pkg::smdr_ctrl_t    ctrl,
  output logic [OPERAND_BITS-1:0] rem,
  output logic [OPERAND_BITS-2:0] dvd,
  output logic [OPERAND_BITS-1:0] dsr,
  output logic [OPERAND_BITS-1:0] aval
);

  localparam int W = OPERAND_BITS;

  logic [W-1:0] a_in, b_in, c_in;
  logic [W-1:0] ma_next, mb_next, mc_next;

  smdr_pkg::smdr_ctrl_t ctrl0, ctrl1, ctrl2_next;
  logic [W-1:0]   a0, ma0, mb0, mc0;
  logic [W-1:0]   a1, mc1;
  logic [2*W-1:0] prod1;
  logic [2*W-2:0] sum_next;

  assign a_in = op.multiplicand[W-1:0];
  assign b_in = op.multiplier[W-1:0];
  assign c_in = op.divisor[W-1:0];

  assign ma_next = a_in[W-1] ? (~a_in + 1'b1) : a_in;
  assign mb_next = b_in[W-1] ? (~b_in + 1'b1) : b_in;
  assign mc_next = c_in[W-1] ? (~c_in + 1'b1) : c_in;

  // Decode stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl0 <= '0;
    end else if (en) begin
      ctrl0.valid  <= in_valid;
      ctrl0.bypass <= (a_in == '0) || (b_in == c_in);
      ctrl0.neg    <= a_in[W-1] ^ b_in[W-1] ^ c_in[W-1];
      ctrl0.ovf    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a0  <= a_in;
      ma0 <= ma_next;
      mb0 <= mb_next;
      mc0 <= mc_next;
    end
  end

  // Product stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl1 <= '0;
    end else if (en) begin
      ctrl1 <= ctrl0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod1 <= (2*W)'(ma0) * (2*W)'(mb0);
      a1    <= a0;
      mc1   <= mc0;
    end
  end

  // Rounding add; the product of two magnitudes never exceeds 2^(2W-2).
  assign sum_next = prod1[2*W-2:0] + (2*W-1)'(mc1 >> 1);

  // Quotient fits W-1 bits only when the upper part is below the divisor.
  always_comb begin
    ctrl2_next     = ctrl1;
    ctrl2_next.ovf = (sum_next[2*W-2:W-1] >= mc1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= '0;
    end else if (en) begin
      ctrl <= ctrl2_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem  <= sum_next[2*W-2:W-1];
      dvd  <= sum_next[W-2:0];
      dsr  <= mc1;
      aval <= a1;
    end
  end

endmodule

// ===== src/smdr_cell.sv =====
// One restoring-division cell: resolves one quotient bit per item and hands on.
// Depends on smdr_pkg.
module smdr_cell #(
  parameter int OPERAND_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  smdr_pkg::smdr_ctrl_t    ctrl_in,
  input  logic [OPERAND_BITS-1:0] rem_in,
  input  logic [OPERAND_BITS-2:0] dvd_in,
  input  logic [OPERAND_BITS-2:0] quo_in,
  input  logic [OPERAND_BITS-1:0] dsr_in,
  input  logic [OPERAND_BITS-1:0] aval_in,
  output smdr_pkg::smdr_ctrl_t    ctrl_out,
  output logic [OPERAND_BITS-1:0] rem_out,
  output logic [OPERAND_BITS-2:0] dvd_out,
  output logic [OPERAND_BITS-2:0] quo_out,
  output logic [OPERAND_BITS-1:0] dsr_out,
  output logic [OPERAND_BITS-1:0] aval_out
);

  localparam int W = OPERAND_BITS;

  logic [W:0]   trial;
  logic [W:0]   diff;
  logic         qbit;
  logic [W-1:0] rem_next;

  assign trial    = {rem_in, dvd_in[W-2]};
  assign diff     = trial - {1'b0, dsr_in};
  assign qbit     = (trial >= {1'b0, dsr_in});
  assign rem_next = qbit ? diff[W-1:0] : trial[W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out <= '0;
    end else if (en) begin
      ctrl_out <= ctrl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= rem_next;
      dvd_out  <= {dvd_in[W-3:0], 1'b0};
      quo_out  <= {quo_in[W-3:0], qbit};
      dsr_out  <= dsr_in;
      aval_out <= aval_in;
    end
  end

endmodule

// ===== src/signed_mul_div_rounded_core.sv =====
// Rounded signed multiply-divide core: round(a*b/c), saturated.
// Stages from accept to result valid:
//   decode, product, rounding add, OPERAND_BITS-1 division cells, result register.
// One item per cycle unless the output stalls; one quotient bit per division cell.
// Reset (rst, synchronous) empties the pipeline, dropping any item in flight.
// Depends on smdr_pkg, smdr_front, smdr_cell.
module signed_mul_div_rounded_core #(
  parameter int OPERAND_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 op_valid,
  output logic                 op_stall,
  input  smdr_pkg::smdr_op_t   op,
  output logic                 res_valid,
  input  logic                 res_stall,
  output smdr_pkg::smdr_res_t  res
);

  localparam int W      = OPERAND_BITS;
  localparam int NCELLS = W - 1;
  localparam logic [W-1:0] QMAX = {1'b0, {(W-1){1'b1}}};

  // The whole pipeline moves together; it freezes only while a finished
  // item sits in the result register and the consumer stalls.
  logic en;
  assign en       = !(res_valid && res_stall);
  assign op_stall = !en;

  // Cell chain, index 0 is the front end's output.
  smdr_pkg::smdr_ctrl_t ctrl_c [NCELLS+1];
  logic [W-1:0] rem_c  [NCELLS+1];
  logic [W-2:0] dvd_c  [NCELLS+1];
  logic [W-2:0] quo_c  [NCELLS+1];
  logic [W-1:0] dsr_c  [NCELLS+1];
  logic [W-1:0] aval_c [NCELLS+1];

  smdr_front #(.OPERAND_BITS(W)) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (op_valid),
    .op       (op),
    .ctrl     (ctrl_c[0]),
    .rem      (rem_c[0]),
    .dvd      (dvd_c[0]),
    .dsr      (dsr_c[0]),
    .aval     (aval_c[0])
  );

  assign quo_c[0] = '0;

  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    smdr_cell #(.OPERAND_BITS(W)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .ctrl_in  (ctrl_c[i]),
      .rem_in   (rem_c[i]),
      .dvd_in   (dvd_c[i]),
      .quo_in   (quo_c[i]),
      .dsr_in   (dsr_c[i]),
      .aval_in  (aval_c[i]),
      .ctrl_out (ctrl_c[i+1]),
      .rem_out  (rem_c[i+1]),
      .dvd_out  (dvd_c[i+1]),
      .quo_out  (quo_c[i+1]),
      .dsr_out  (dsr_c[i+1]),
      .aval_out (aval_c[i+1])
    );
  end

  // Result formation: bypass passes a through, overflow and a zero divisor
  // clamp to the positive limit, then apply the sign.
  smdr_pkg::smdr_ctrl_t ctrl_last;
  logic [W-1:0]        qmag;
  logic signed [W-1:0] qres_w;
  logic signed [31:0]  qres_ext;
  logic                sat_next;

  assign ctrl_last = ctrl_c[NCELLS];

  always_comb begin
    qmag     = ctrl_last.ovf ? QMAX : {1'b0, quo_c[NCELLS]};
    qres_w   = ctrl_last.neg ? signed'(~qmag + 1'b1) : signed'(qmag);
    sat_next = ctrl_last.ovf;
    if (ctrl_last.bypass) begin
      qres_w   = signed'(aval_c[NCELLS]);
      sat_next = 1'b0;
    end
    qres_ext = 32'(qres_w);  // sign-extend to the port width
  end

  // Result register: hold while stalled, advance with the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= ctrl_last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.quotient  <= qres_ext;
      res.saturated <= sat_next;
    end
  end

endmodule

// ===== src/smdr_chk.sv =====
// Port-level checker for the rounded multiply-divide core, bound to the top level.
// Depends on smdr_pkg and signed_mul_div_rounded_core.
module smdr_chk #(
  parameter int OPERAND_BITS = 32
) (
  input logic                clk,
  input logic                rst,
  input logic                op_valid,
  input logic                op_stall,
  input smdr_pkg::smdr_op_t  op,
  input logic                res_valid,
  input logic                res_stall,
  input smdr_pkg::smdr_res_t res
);

  localparam logic [OPERAND_BITS-1:0] QMAX_W = {1'b0, {(OPERAND_BITS-1){1'b1}}};

  logic signed [31:0] qmax_pos;
  logic signed [31:0] qmax_neg;
  logic               op_seen;

  assign qmax_pos = signed'(32'(QMAX_W));
  assign qmax_neg = -qmax_pos;
  assign op_seen  = op_valid || (op.multiplicand == op.multiplicand);

  // Hold a stalled result.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result changed");

  // Stall the input only when a finished item is blocked at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    op_stall |-> res_valid && res_stall && op_seen)
    else $error("input stalled without a blocked result");

  // A saturated result carries exactly the signed limit.
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.saturated |-> res.quotient == qmax_pos || res.quotient == qmax_neg)
    else $error("saturated result is not the limit");

  // No result is valid right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

endmodule

bind signed_mul_div_rounded_core smdr_chk #(.OPERAND_BITS(OPERAND_BITS)) u_smdr_chk (
  .clk       (clk),
  .rst       (rst),
  .op_valid  (op_valid),
  .op_stall  (op_stall),
  .op        (op),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);
